### rtl/core/msp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the multi stepper pulse generator.
// ----------------------------------------------------------------------------
package msp_pkg;

   localparam int NUM_MOTORS = 2;
   localparam int MIDX_W     = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
   localparam int PIN_W      = 2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_REV = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MICROSTEP     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD   = 2'd2;

   localparam int DVD_W = 42;
   localparam int DSR_W = 20;
   localparam int DIV_CNT_W = $clog2(DVD_W + 1);
   localparam int RND_W = 41;

   localparam logic [15:0] SPR_RESET  = 16'd200;
   localparam logic [8:0]  MF_RESET   = 9'd1;
   localparam logic [15:0] TP_RESET   = 16'd100;
   localparam logic [DSR_W-1:0] DEG_PER_REV = 20'd360;
   localparam logic [RND_W-1:0] HALF_REV    = 41'd180;
   localparam logic [DVD_W-1:0] US_PER_SEC  = 42'd1000000;
   localparam logic [15:0] MAX_INTERVAL = 16'hFFFF;
   // ceil(2^33 / 45), exact floor for dividends below 2^27
   localparam logic [27:0] RECIP_45 = 28'd190887436;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_MOVE  = 2'd1,
      REQ_ABORT = 2'd2,
      REQ_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [2:0]  motor_index;
      logic [15:0] move_angle;
      logic        clockwise;
      logic [19:0] step_rate;
   } req_item_type;

   typedef struct packed {
      logic             accepted;
      logic [PIN_W-1:0] step_pins;
      logic [PIN_W-1:0] dir_pins;
      logic [PIN_W-1:0] busy_flags;
   } rsp_item_type;

   typedef struct packed {
      kind_type     kind;
      logic         idx_ok;
      req_item_type req;
   } cmd_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_req_type;

endpackage

`default_nettype wire

### rtl/core/multi_stepper_pulse_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_stepper_pulse_generator_unit
// Step/direction pulse generator for several stepper motors.
//
//   channel  ports                          role
//   request  req_valid req_stall req_data   tick, move or abort in
//   response rsp_valid rsp_stall rsp_data   accepted flag and pin levels out
//   config   csr_we csr_index csr_wdata     register writes
//
// ticks, aborts and moves rejected on index, busy or zero angle are answered from idle
// a move rejected for a zero step count is answered after the multiplies and the divide by 360
// a started move adds two multiplies, a divide by 360
// in reciprocal steps and two 42-step divides on the shared divider
// reset is synchronous and restores register and motor defaults
// a stalled response holds the back end, until full the two-entry queue keeps accepting
// ----------------------------------------------------------------------------
module multi_stepper_pulse_generator_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire msp_pkg::req_item_type          req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output msp_pkg::rsp_item_type               rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [msp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [msp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic                  q_valid;
   logic                  q_pop;
   msp_pkg::cmd_type      q_cmd;
   msp_pkg::div_req_type  div_req;
   logic                  div_done;
   logic [msp_pkg::DVD_W-1:0] div_quot;

   msp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop)
   );

   msp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   msp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .div_req   (div_req),
      .div_done  (div_done),
      .div_quot  (div_quot),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/core/msp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp_queue
// Front end: accepts requests, classifies them and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module msp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire msp_pkg::req_item_type req_data,
   output logic                       q_valid,
   output msp_pkg::cmd_type           q_cmd,
   input  wire logic                  q_pop
);

   msp_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   msp_pkg::cmd_type cls;
   logic       push;
   logic       pop;

   always_comb begin
      cls.req    = req_data;
      cls.kind   = msp_pkg::kind_type'(req_data.req_type);
      cls.idx_ok = (32'(req_data.motor_index) < msp_pkg::NUM_MOTORS);
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (count_ff != 2'd0);
   assign q_valid   = (count_ff != 2'd0);
   assign q_cmd     = entry_ff[rd_ptr_ff];
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

### rtl/core/msp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msp_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire msp_pkg::div_req_type        div_req,
   output logic                             div_done,
   output logic [msp_pkg::DVD_W-1:0]        div_quot
);

   logic [msp_pkg::DVD_W-1:0]     dvd_ff;
   logic [msp_pkg::DSR_W:0]       rem_ff;
   logic [msp_pkg::DSR_W-1:0]     dsr_ff;
   logic [msp_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [msp_pkg::DSR_W:0]       sh;
   logic                          ge;

   assign sh       = {rem_ff[msp_pkg::DSR_W-1:0], dvd_ff[msp_pkg::DVD_W-1]};
   assign ge       = (sh >= {1'b0, dsr_ff});
   assign div_done = done_ff;
   assign div_quot = dvd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= msp_pkg::DIV_CNT_W'(msp_pkg::DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == msp_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (div_req.start) begin
         dvd_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[msp_pkg::DVD_W-2:0], ge};
         rem_ff <= ge ? (sh - {1'b0, dsr_ff}) : sh;
      end
   end

endmodule

`default_nettype wire

### rtl/core/msp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp_back
// Back end: motor state, configuration, move setup sequencer and the
// response register.
// ----------------------------------------------------------------------------
module msp_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [msp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [msp_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  wire logic                                  q_valid,
   input  wire msp_pkg::cmd_type                      q_cmd,
   output logic                                       q_pop,
   output msp_pkg::div_req_type                       div_req,
   input  wire logic                                  div_done,
   input  wire logic [msp_pkg::DVD_W-1:0]             div_quot,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output msp_pkg::rsp_item_type                      rsp_data
);

   localparam int N = msp_pkg::NUM_MOTORS;
   localparam int W = msp_pkg::MIDX_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_ROUND, ST_QHI, ST_REM, ST_QLO, ST_STEPS,
      ST_DIV_PERIOD, ST_DIV_TICKS, ST_FINISH
   } state_type;

   // floor(v / 360) as floor((v >> 3) / 45) by reciprocal, v below 2^30
   function automatic logic [21:0] div360(input logic [29:0] v);
      logic [54:0] p;
      p = 55'(v[29:3]) * 55'(msp_pkg::RECIP_45);
      return p[54:33];
   endfunction

   state_type state_ff;

   logic [15:0] spr_ff;
   logic [8:0]  mf_ff;
   logic [15:0] tp_ff;

   logic [31:0] steps_left_ff [N];
   logic        busy_ff       [N];
   logic [15:0] interval_ff   [N];
   logic [15:0] wait_ff       [N];
   logic        pulse_ff      [N];
   logic        dir_ff        [N];
   logic [31:0] steps_left_in [N];
   logic        busy_in       [N];
   logic [15:0] interval_in   [N];
   logic [15:0] wait_in       [N];
   logic        pulse_in      [N];
   logic        dir_in        [N];

   logic [W-1:0] mv_idx_ff;
   logic [15:0]  mv_angle_ff;
   logic         mv_cw_ff;
   logic [19:0]  mv_rate_ff;
   logic         mv_ok_ff;
   logic [31:0]  prod_ff;
   logic [40:0]  prod2_ff;
   logic [40:0]  x_ff;
   logic [11:0]  qh_ff;
   logic [29:0]  z_ff;
   logic [20:0]  ql_ff;
   logic [31:0]  mv_steps_ff;
   logic [20:0]  period_ff;
   logic [15:0]  mv_interval_ff;

   logic         rsp_valid_ff;
   msp_pkg::rsp_item_type rsp_ff;
   msp_pkg::rsp_item_type rsp_in;
   msp_pkg::div_req_type  div_ff;

   logic         out_free;
   logic [W-1:0] q_idx;
   logic         move_ok;
   logic         start_mv;
   logic         do_now;
   logic         finish;
   logic         apply_tick;
   logic         apply_abort;
   logic         apply_move;
   logic [15:0]  tp_eff;
   logic [19:0]  rate_eff;
   logic [21:0]  qh_full;
   logic [21:0]  ql_full;
   logic [19:0]  rh_full;
   logic [32:0]  steps_q;
   logic [31:0]  steps_sat;
   logic [15:0]  ticks_sat;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_idx    = q_cmd.req.motor_index[W-1:0];
   assign move_ok  = q_cmd.idx_ok && !busy_ff[q_idx] && (q_cmd.req.move_angle != 16'd0);
   assign start_mv = (state_ff == ST_IDLE) && q_valid &&
                     (q_cmd.kind == msp_pkg::REQ_MOVE) && move_ok;
   assign do_now   = (state_ff == ST_IDLE) && q_valid && out_free && !start_mv;
   assign finish   = (state_ff == ST_FINISH) && out_free;
   assign q_pop    = start_mv || do_now;
   assign apply_tick  = do_now && (q_cmd.kind == msp_pkg::REQ_TICK);
   assign apply_abort = do_now && (q_cmd.kind == msp_pkg::REQ_ABORT) && q_cmd.idx_ok;
   assign apply_move  = finish && mv_ok_ff;

   assign tp_eff    = (tp_ff == 16'd0) ? 16'd1 : tp_ff;
   assign rate_eff  = (mv_rate_ff == 20'd0) ? 20'd1 : mv_rate_ff;

   // rounded count split in a high and a low part, each divided by 360
   assign qh_full   = div360({10'd0, x_ff[40:21]});
   assign rh_full   = x_ff[40:21] - 20'(qh_ff) * msp_pkg::DEG_PER_REV;
   assign ql_full   = div360(z_ff);
   assign steps_q   = {qh_ff, ql_ff};
   assign steps_sat = steps_q[32] ? 32'hFFFF_FFFF : steps_q[31:0];
   assign ticks_sat = (div_quot[msp_pkg::DVD_W-1:16] != '0) ? msp_pkg::MAX_INTERVAL :
                      ((div_quot[15:0] == 16'd0) ? 16'd1 : div_quot[15:0]);

   assign div_req   = div_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [31:0] dec;
      dec = '0;
      for (int i = 0; i < N; i++) begin
         steps_left_in[i] = steps_left_ff[i];
         busy_in[i]       = busy_ff[i];
         interval_in[i]   = interval_ff[i];
         wait_in[i]       = wait_ff[i];
         pulse_in[i]      = pulse_ff[i];
         dir_in[i]        = dir_ff[i];
         if (apply_tick && busy_ff[i]) begin
            if (pulse_ff[i]) begin
               dec = (steps_left_ff[i] != 32'd0) ? steps_left_ff[i] - 32'd1 : 32'd0;
               pulse_in[i]      = 1'b0;
               steps_left_in[i] = dec;
               wait_in[i]       = 16'd0;
               if (dec == 32'd0) begin
                  busy_in[i] = 1'b0;
               end
            end else begin
               wait_in[i] = wait_ff[i] + 16'd1;
               if (wait_ff[i] >= interval_ff[i]) begin
                  pulse_in[i] = 1'b1;
               end
            end
         end
         if (apply_abort && (q_idx == W'(i))) begin
            steps_left_in[i] = 32'd0;
            busy_in[i]       = 1'b0;
            pulse_in[i]      = 1'b0;
            wait_in[i]       = 16'd0;
         end
         if (apply_move && (mv_idx_ff == W'(i))) begin
            dir_in[i]        = mv_cw_ff;
            interval_in[i]   = mv_interval_ff;
            wait_in[i]       = 16'd0;
            pulse_in[i]      = 1'b0;
            steps_left_in[i] = mv_steps_ff;
            busy_in[i]       = 1'b1;
         end
      end
      rsp_in = '0;
      rsp_in.accepted = apply_move;
      for (int i = 0; i < msp_pkg::PIN_W; i++) begin
         if (i < N) begin
            rsp_in.step_pins[i]  = pulse_in[i];
            rsp_in.dir_pins[i]   = dir_in[i];
            rsp_in.busy_flags[i] = busy_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_ff.start <= 1'b0;
         spr_ff       <= msp_pkg::SPR_RESET;
         mf_ff        <= msp_pkg::MF_RESET;
         tp_ff        <= msp_pkg::TP_RESET;
         for (int i = 0; i < N; i++) begin
            steps_left_ff[i] <= 32'd0;
            busy_ff[i]       <= 1'b0;
            interval_ff[i]   <= 16'd1;
            wait_ff[i]       <= 16'd0;
            pulse_ff[i]      <= 1'b0;
            dir_ff[i]        <= 1'b0;
         end
      end else begin
         div_ff.start <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               msp_pkg::CSR_STEPS_PER_REV: spr_ff <= csr_wdata;
               msp_pkg::CSR_MICROSTEP:     mf_ff  <= csr_wdata[8:0];
               msp_pkg::CSR_TICK_PERIOD:   tp_ff  <= csr_wdata;
               default: ;
            endcase
         end
         for (int i = 0; i < N; i++) begin
            steps_left_ff[i] <= steps_left_in[i];
            busy_ff[i]       <= busy_in[i];
            interval_ff[i]   <= interval_in[i];
            wait_ff[i]       <= wait_in[i];
            pulse_ff[i]      <= pulse_in[i];
            dir_ff[i]        <= dir_in[i];
         end
         if (do_now || finish) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= rsp_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start_mv) begin
                  mv_idx_ff   <= q_idx;
                  mv_angle_ff <= q_cmd.req.move_angle;
                  mv_cw_ff    <= q_cmd.req.clockwise;
                  mv_rate_ff  <= q_cmd.req.step_rate;
                  state_ff    <= ST_MUL1;
               end
            end
            ST_MUL1: begin
               prod_ff  <= 32'(mv_angle_ff) * 32'(spr_ff);
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               prod2_ff <= 41'(prod_ff) * 41'(mf_ff);
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               x_ff     <= prod2_ff + msp_pkg::HALF_REV;
               state_ff <= ST_QHI;
            end
            ST_QHI: begin
               qh_ff    <= qh_full[11:0];
               state_ff <= ST_REM;
            end
            ST_REM: begin
               z_ff     <= {rh_full[8:0], x_ff[20:0]};
               state_ff <= ST_QLO;
            end
            ST_QLO: begin
               ql_ff    <= ql_full[20:0];
               state_ff <= ST_STEPS;
            end
            ST_STEPS: begin
               mv_steps_ff <= steps_sat;
               if (steps_sat == 32'd0) begin
                  mv_ok_ff <= 1'b0;
                  state_ff <= ST_FINISH;
               end else begin
                  mv_ok_ff        <= 1'b1;
                  div_ff.start    <= 1'b1;
                  div_ff.dividend <= msp_pkg::US_PER_SEC;
                  div_ff.divisor  <= rate_eff;
                  state_ff        <= ST_DIV_PERIOD;
               end
            end
            ST_DIV_PERIOD: begin
               if (div_done) begin
                  period_ff <= (div_quot[20:0] == 21'd0) ? 21'd1 : div_quot[20:0];
                  state_ff  <= ST_DIV_TICKS;
               end
            end
            ST_DIV_TICKS: begin
               if (period_ff != 21'd0) begin
                  div_ff.start    <= 1'b1;
                  div_ff.dividend <= 42'(period_ff) + 42'(tp_eff) - 42'd1;
                  div_ff.divisor  <= 20'(tp_eff);
                  period_ff       <= 21'd0;
               end else if (div_done) begin
                  mv_interval_ff <= ticks_sat;
                  state_ff       <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (finish) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi stepper pulse generator. Ticks, moves,
// aborts and unused codes are sent under random idling and response stall;
// a scoreboard class tracks the motor state and checks every response field.
// ----------------------------------------------------------------------------
module tb;

   class pulse_scoreboard;
      logic [15:0] spr;
      logic [8:0]  msf;
      logic [15:0] tick_us;
      logic [31:0] steps_left [msp_pkg::NUM_MOTORS];
      bit          busy [msp_pkg::NUM_MOTORS];
      logic [15:0] interval [msp_pkg::NUM_MOTORS];
      logic [15:0] wait_cnt [msp_pkg::NUM_MOTORS];
      bit          pulse [msp_pkg::NUM_MOTORS];
      bit          dir [msp_pkg::NUM_MOTORS];
      msp_pkg::rsp_item_type pins_q [$];
      int errors;
      int moves_started;
      int pulses_seen;

      function new();
         spr = msp_pkg::SPR_RESET;
         msf = msp_pkg::MF_RESET;
         tick_us = msp_pkg::TP_RESET;
         errors = 0;
         moves_started = 0;
         pulses_seen = 0;
         for (int i = 0; i < msp_pkg::NUM_MOTORS; i++) begin
            steps_left[i] = 0;
            busy[i] = 0;
            interval[i] = 1;
            wait_cnt[i] = 0;
            pulse[i] = 0;
            dir[i] = 0;
         end
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] val);
         if (idx == msp_pkg::CSR_STEPS_PER_REV) spr = val;
         else if (idx == msp_pkg::CSR_MICROSTEP) msf = val[8:0];
         else if (idx == msp_pkg::CSR_TICK_PERIOD) tick_us = val;
      endfunction

      function logic [31:0] steps_for_angle(logic [15:0] angle);
         logic [63:0] n;
         n = (64'(angle) * 64'(spr) * 64'(msf) + 64'd180) / 64'd360;
         if (n > 64'hFFFF_FFFF) n = 64'hFFFF_FFFF;
         return n[31:0];
      endfunction

      function logic [15:0] rate_to_ticks(logic [19:0] rate);
         logic [31:0] tp, r, period, ticks;
         tp = (tick_us == 0) ? 32'd1 : 32'(tick_us);
         r = (rate == 0) ? 32'd1 : 32'(rate);
         period = 32'd1000000 / r;
         if (period == 0) period = 32'd1;
         ticks = (period + tp - 32'd1) / tp;
         if (ticks < 1) ticks = 32'd1;
         if (ticks > 32'hFFFF) ticks = 32'hFFFF;
         return ticks[15:0];
      endfunction

      function void note(msp_pkg::req_item_type r);
         msp_pkg::rsp_item_type e;
         logic [31:0] steps;
         logic [15:0] old;
         e = '0;
         case (r.req_type)
            msp_pkg::REQ_TICK: begin
               for (int i = 0; i < msp_pkg::NUM_MOTORS; i++) begin
                  if (!busy[i]) continue;
                  if (pulse[i]) begin
                     pulse[i] = 0;
                     if (steps_left[i] > 0) steps_left[i]--;
                     wait_cnt[i] = 0;
                     if (steps_left[i] == 0) busy[i] = 0;
                  end else begin
                     old = wait_cnt[i];
                     wait_cnt[i] = old + 16'd1;
                     if (old >= interval[i]) begin
                        pulse[i] = 1;
                        pulses_seen++;
                     end
                  end
               end
            end
            msp_pkg::REQ_MOVE: begin
               if (r.motor_index < msp_pkg::NUM_MOTORS && !busy[r.motor_index] &&
                   r.move_angle != 0)
               begin
                  steps = steps_for_angle(r.move_angle);
                  if (steps != 0) begin
                     dir[r.motor_index] = r.clockwise;
                     interval[r.motor_index] = rate_to_ticks(r.step_rate);
                     wait_cnt[r.motor_index] = 0;
                     pulse[r.motor_index] = 0;
                     steps_left[r.motor_index] = steps;
                     busy[r.motor_index] = 1;
                     e.accepted = 1'b1;
                     moves_started++;
                  end
               end
            end
            msp_pkg::REQ_ABORT: begin
               if (r.motor_index < msp_pkg::NUM_MOTORS) begin
                  steps_left[r.motor_index] = 0;
                  busy[r.motor_index] = 0;
                  pulse[r.motor_index] = 0;
                  wait_cnt[r.motor_index] = 0;
               end
            end
            default: ;
         endcase
         for (int i = 0; i < msp_pkg::NUM_MOTORS && i < msp_pkg::PIN_W; i++) begin
            e.step_pins[i] = pulse[i];
            e.dir_pins[i] = dir[i];
            e.busy_flags[i] = busy[i];
         end
         pins_q.push_back(e);
      endfunction

      function void check(msp_pkg::rsp_item_type got);
         msp_pkg::rsp_item_type e;
         if (pins_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", got);
            return;
         end
         e = pins_q.pop_front();
         if (got.accepted !== e.accepted || got.step_pins !== e.step_pins ||
             got.dir_pins !== e.dir_pins || got.busy_flags !== e.busy_flags) begin
            errors++;
            if (errors <= 10)
               $display("mismatch acc %b/%b step %b/%b dir %b/%b busy %b/%b (exp/got)",
                        e.accepted, got.accepted, e.step_pins, got.step_pins,
                        e.dir_pins, got.dir_pins, e.busy_flags, got.busy_flags);
         end
      endfunction

      function int pending();
         return pins_q.size();
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   msp_pkg::req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   msp_pkg::rsp_item_type rsp_data;
   logic csr_we = 0;
   logic [msp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [msp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   bit quiet = 0;
   int sent = 0;
   pulse_scoreboard sb;

   multi_stepper_pulse_generator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #30ms;
      $display("tb: done, errors");
      $finish;
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_data);
   end

   initial begin
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_stall <= 0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   task automatic send(msp_pkg::req_item_type d);
      bit ok;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= d;
      do begin
         @(negedge clock);
         ok = !req_stall;
         @(posedge clock);
      end while (!ok);
      sb.note(d);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic set_regs(logic [15:0] s, logic [15:0] m, logic [15:0] t);
      drain();
      write_reg(msp_pkg::CSR_STEPS_PER_REV, s);
      write_reg(msp_pkg::CSR_MICROSTEP, m);
      write_reg(msp_pkg::CSR_TICK_PERIOD, t);
      csr_we <= 0;
      @(posedge clock);
   endtask

   function automatic msp_pkg::req_item_type make(logic [1:0] k, int m, int a, int cw,
                                                  int r);
      msp_pkg::req_item_type d;
      d.req_type = k;
      d.motor_index = 3'(m);
      d.move_angle = 16'(a);
      d.clockwise = 1'(cw);
      d.step_rate = 20'(r);
      return d;
   endfunction

   function automatic msp_pkg::req_item_type rand_req();
      msp_pkg::req_item_type d;
      int p;
      d = make(msp_pkg::REQ_TICK, $urandom_range(0, 1), $urandom_range(1, 12),
               $urandom_range(0, 1), $urandom_range(0, 20'hFFFFF));
      p = $urandom_range(0, 99);
      if (p < 70) d.req_type = msp_pkg::REQ_TICK;
      else if (p < 88) d.req_type = msp_pkg::REQ_MOVE;
      else if (p < 97) d.req_type = msp_pkg::REQ_ABORT;
      else d.req_type = msp_pkg::REQ_NONE;
      if ($urandom_range(0, 9) == 0) d.motor_index = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 15) == 0) d.move_angle = 16'($urandom_range(0, 16'hFFFF));
      if ($urandom_range(0, 3) == 0) d.step_rate = 20'($urandom_range(0, 40000));
      return d;
   endfunction

   task automatic random_items(int n);
      repeat (n) send(rand_req());
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 0;
      repeat (2) @(posedge clock);

      // directed part under reset settings
      send(make(msp_pkg::REQ_TICK, 0, 0, 0, 0));
      send(make(msp_pkg::REQ_MOVE, 0, 1, 1, 0));
      send(make(msp_pkg::REQ_MOVE, 1, 16'hFFFF, 0, 20'hFFFFF));
      send(make(msp_pkg::REQ_MOVE, 0, 90, 0, 500));
      send(make(msp_pkg::REQ_MOVE, 7, 90, 1, 500));
      send(make(msp_pkg::REQ_MOVE, 2, 90, 1, 500));
      send(make(msp_pkg::REQ_ABORT, 1, 0, 0, 0));
      send(make(msp_pkg::REQ_MOVE, 1, 0, 1, 500));
      send(make(msp_pkg::REQ_ABORT, 5, 0, 0, 0));
      send(make(msp_pkg::REQ_NONE, 3, 16'hFFFF, 1, 20'hFFFFF));
      repeat (6) send(make(msp_pkg::REQ_TICK, 0, 0, 0, 0));
      send(make(msp_pkg::REQ_MOVE, 1, 360, 1, 20'hFFFFF));
      repeat (6) send(make(msp_pkg::REQ_TICK, 0, 0, 0, 0));
      random_items(230);

      // single step per rev, zero-step moves rejected
      set_regs(16'd1, 16'd1, 16'd1);
      send(make(msp_pkg::REQ_MOVE, 0, 1, 1, 1));
      send(make(msp_pkg::REQ_MOVE, 0, 180, 1, 1));
      send(make(msp_pkg::REQ_ABORT, 0, 0, 0, 0));
      random_items(240);

      // large unsaturated step count, widest steps per rev and tick period
      set_regs(16'hFFFF, 16'd256, 16'hFFFF);
      send(make(msp_pkg::REQ_MOVE, 0, 16'hFFFF, 1, 0));
      send(make(msp_pkg::REQ_MOVE, 1, 16'hFFFF, 1, 20'hFFFFF));
      random_items(240);

      // zero tick period and out-of-range microstep bits
      set_regs(16'd400, 16'hFE10, 16'd0);
      random_items(240);

      // pause until the block has answered everything before going on
      drain();
      set_regs(16'd0, 16'd0, 16'd7);
      random_items(40);

      repeat (3) begin
         set_regs(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 32)),
                  16'($urandom_range(1, 65535)));
         write_reg(2'd3, 16'($urandom_range(0, 16'hFFFF)));
         csr_we <= 0;
         random_items(180);
      end

      set_regs(msp_pkg::SPR_RESET, 16'(msp_pkg::MF_RESET), msp_pkg::TP_RESET);
      quiet = 1;
      random_items(200);
      drain();
      repeat (20) @(posedge clock);

      $display("tb: %0d requests sent, %0d moves started, %0d step pulses",
               sent, sb.moves_started, sb.pulses_seen);
      $display("tb: covered ticks, moves, aborts, unused codes and several register settings");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
